### src/eau_pkg.sv
// ----------------------------------------------------------------------------
// Effective address unit package
// Shared types, field codes and helper functions of the effective address unit.
// ----------------------------------------------------------------------------
package eau_pkg;

   localparam int REQ_TDATA_WIDTH = 240;
   localparam int RSP_TDATA_WIDTH = 32;

   typedef enum logic [3:0] {
      EA_DATA_REG    = 4'd0,
      EA_ADDR_REG    = 4'd1,
      EA_ADDR_IND    = 4'd2,
      EA_POSTINC     = 4'd3,
      EA_PREDEC      = 4'd4,
      EA_DISP16      = 4'd5,
      EA_INDEX       = 4'd6,
      EA_ABS_WORD    = 4'd7,
      EA_ABS_LONG    = 4'd8,
      EA_PC_DISP16   = 4'd9,
      EA_PC_INDEX    = 4'd10,
      EA_IMMEDIATE   = 4'd11
   } ea_mode_type;

   typedef enum logic [1:0] {
      KIND_ADDRESS    = 2'd0,
      KIND_OPERAND    = 2'd1,
      KIND_READ_REQ   = 2'd2,
      KIND_UNEXPECTED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2
   } size_type;

   typedef enum logic {
      MODE_COMPUTE  = 1'b0,
      MODE_INDIRECT = 1'b1
   } mode_type;

   localparam logic [2:0] STACK_REG = 3'd7;

   localparam logic [1:0] DISP_NONE = 2'd0;
   localparam logic [1:0] DISP_NULL = 2'd1;
   localparam logic [1:0] DISP_WORD = 2'd2;
   localparam logic [1:0] DISP_LONG = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [3:0]  ea_mode;
      logic [1:0]  size;
      logic [2:0]  reg_num;
      logic [31:0] base_value;
      logic [31:0] pc_value;
      logic [31:0] index_value;
      logic [15:0] ext_word;
      logic [15:0] ext_word_next;
      logic [31:0] base_disp_words;
      logic [31:0] outer_disp_words;
      logic [31:0] indirect_data;
   } eau_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
   } eau_rsp_type;

   typedef struct packed {
      logic        pending;
      logic [31:0] addend;
   } eau_state_type;

   typedef struct packed {
      logic        indirect;
      logic [31:0] addr;
      logic [31:0] addend;
   } eau_index_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

### src/eau_index.sv
// ----------------------------------------------------------------------------
// Indexed address decoder
// Decodes brief and full extension words and forms the indexed address.
// ----------------------------------------------------------------------------
module eau_index (
   input  logic [31:0]            base_in,
   input  logic [31:0]            index_value,
   input  logic [15:0]            ext_word,
   input  logic [31:0]            base_disp_words,
   input  logic [31:0]            outer_disp_words,
   output eau_pkg::eau_index_type result
);
   import eau_pkg::*;

   logic [31:0] index_ext;
   logic [31:0] index_scaled;
   logic [31:0] base_sel;
   logic [31:0] index_sel;
   logic [31:0] disp;
   logic [31:0] outer;
   logic [31:0] pre_sum;
   logic [31:0] early_index;
   logic        full_format;
   logic        indirect;
   logic        post_index;

   assign index_ext    = ext_word[11] ? index_value : sext16(index_value[15:0]);
   assign index_scaled = index_ext << ext_word[10:9];
   assign full_format  = ext_word[8];
   assign indirect     = full_format && (ext_word[1:0] != DISP_NONE);
   assign post_index   = ext_word[2];

   always_comb begin
      if (!full_format) begin
         base_sel  = base_in;
         index_sel = index_scaled;
         disp      = sext8(ext_word[7:0]);
         outer     = '0;
      end else begin
         base_sel  = ext_word[7] ? '0 : base_in;
         index_sel = ext_word[6] ? '0 : index_scaled;
         unique case (ext_word[5:4])
            DISP_WORD: disp = sext16(base_disp_words[15:0]);
            DISP_LONG: disp = base_disp_words;
            default:   disp = '0;
         endcase
         unique case (ext_word[1:0])
            DISP_WORD: outer = sext16(outer_disp_words[15:0]);
            DISP_LONG: outer = outer_disp_words;
            default:   outer = '0;
         endcase
      end
   end

   assign early_index = (indirect && post_index) ? '0 : index_sel;
   assign pre_sum     = base_sel + disp + early_index;

   assign result.indirect = indirect;
   assign result.addr     = indirect ? pre_sum : pre_sum + outer;
   assign result.addend   = outer + (post_index ? index_sel : '0);

endmodule

### src/eau_calc.sv
// ----------------------------------------------------------------------------
// Effective address calculation
// Selects the result of the addressing mode and the next indirect state.
// ----------------------------------------------------------------------------
module eau_calc (
   input  eau_pkg::eau_req_type   req,
   input  eau_pkg::eau_state_type state_cur,
   output eau_pkg::eau_rsp_type   rsp,
   output eau_pkg::eau_state_type state_next
);
   import eau_pkg::*;

   eau_index_type idx_res;
   logic [31:0]   idx_base;
   logic [31:0]   pc_plus2;
   logic [31:0]   dec_amount;
   logic [31:0]   trunc_value;
   logic [31:0]   imm_value;
   logic [31:0]   long_ext;

   assign pc_plus2 = req.pc_value + 32'd2;
   assign idx_base = (req.ea_mode == EA_PC_INDEX) ? pc_plus2 : req.base_value;
   assign long_ext = {req.ext_word, req.ext_word_next};

   eau_index u_index (
      .base_in          (idx_base),
      .index_value      (req.index_value),
      .ext_word         (req.ext_word),
      .base_disp_words  (req.base_disp_words),
      .outer_disp_words (req.outer_disp_words),
      .result           (idx_res)
   );

   always_comb begin
      unique case (req.size)
         SIZE_BYTE: begin
            trunc_value = {24'd0, req.base_value[7:0]};
            imm_value   = {24'd0, req.ext_word[7:0]};
            dec_amount  = (req.reg_num == STACK_REG) ? 32'd2 : 32'd1;
         end
         SIZE_WORD: begin
            trunc_value = {16'd0, req.base_value[15:0]};
            imm_value   = {16'd0, req.ext_word};
            dec_amount  = 32'd2;
         end
         default: begin
            trunc_value = req.base_value;
            imm_value   = long_ext;
            dec_amount  = 32'd4;
         end
      endcase
   end

   always_comb begin
      rsp        = '{kind: KIND_ADDRESS, value: '0};
      state_next = '{pending: 1'b0, addend: '0};
      if (req.mode == MODE_INDIRECT) begin
         if (state_cur.pending) begin
            rsp.value = req.indirect_data + state_cur.addend;
         end else begin
            rsp.kind   = KIND_UNEXPECTED;
            state_next = state_cur;
         end
      end else begin
         unique case (req.ea_mode)
            EA_DATA_REG, EA_ADDR_REG: begin
               rsp.kind  = KIND_OPERAND;
               rsp.value = trunc_value;
            end
            EA_ADDR_IND, EA_POSTINC: rsp.value = req.base_value;
            EA_PREDEC:    rsp.value = req.base_value - dec_amount;
            EA_DISP16:    rsp.value = req.base_value + sext16(req.ext_word);
            EA_ABS_WORD:  rsp.value = sext16(req.ext_word);
            EA_ABS_LONG:  rsp.value = long_ext;
            EA_PC_DISP16: rsp.value = pc_plus2 + sext16(req.ext_word);
            EA_INDEX, EA_PC_INDEX: begin
               rsp.value = idx_res.addr;
               if (idx_res.indirect) begin
                  rsp.kind   = KIND_READ_REQ;
                  state_next = '{pending: 1'b1, addend: idx_res.addend};
               end
            end
            EA_IMMEDIATE: begin
               rsp.kind  = KIND_OPERAND;
               rsp.value = imm_value;
            end
            default: rsp.value = '0;
         endcase
      end
   end

endmodule

### src/m68020_effective_address_unit.sv
// ----------------------------------------------------------------------------
// 68020 effective address unit
// Computes the effective address or operand of an instruction operand.
// ----------------------------------------------------------------------------
// Each request transfer is held in an input register, the address is formed
// by one pass of adders and selection, and the result lands in an output
// register. The unit takes one request per cycle while the result side is not
// stalled. A request with tuser set delivers the long word of an outstanding
// memory indirect read.
module m68020_effective_address_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [3:0] ea_mode, [5:4] size, [8:6] reg_num, [40:9] base_value,
   // [72:41] pc_value, [104:73] index_value, [120:105] ext_word,
   // [136:121] ext_word_next, [168:137] base_disp_words,
   // [200:169] outer_disp_words, [232:201] indirect_data, [239:233] zero.
   input  logic [eau_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // [0] mode.
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] value.
   output logic [eau_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // [1:0] kind.
   output logic [1:0]                           rsp_tuser
);
   import eau_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   eau_req_type   in_data_ff;
   eau_req_type   req_word;
   logic          out_valid_ff;
   logic          out_valid_in;
   eau_rsp_type   out_data_ff;
   eau_rsp_type   calc_rsp;
   eau_state_type state_ff;
   eau_state_type state_in;
   eau_state_type state_calc;
   logic          advance;
   logic          req_take;

   assign req_word = '{
      mode:             req_tuser,
      ea_mode:          req_tdata[3:0],
      size:             req_tdata[5:4],
      reg_num:          req_tdata[8:6],
      base_value:       req_tdata[40:9],
      pc_value:         req_tdata[72:41],
      index_value:      req_tdata[104:73],
      ext_word:         req_tdata[120:105],
      ext_word_next:    req_tdata[136:121],
      base_disp_words:  req_tdata[168:137],
      outer_disp_words: req_tdata[200:169],
      indirect_data:    req_tdata[232:201]
   };

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   eau_calc u_calc (
      .req        (in_data_ff),
      .state_cur  (state_ff),
      .rsp        (calc_rsp),
      .state_next (state_calc)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign state_in     = advance ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{pending: 1'b0, addend: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_word;
      end
      if (advance) begin
         out_data_ff <= calc_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.value;
   assign rsp_tuser  = out_data_ff.kind;

endmodule

### src/eau_checker.sv
// ----------------------------------------------------------------------------
// Effective address unit checker
// Port level assertions bound to the effective address unit.
// ----------------------------------------------------------------------------
module eau_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [eau_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [eau_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                          rsp_tuser
);
   import eau_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_unexpected_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_UNEXPECTED) |-> (rsp_tdata == '0))
      else $error("Unexpected data result carries a nonzero value.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser)))
      else $error("Stalled result changed.");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && $past(!rsp_tvalid) && !$past(reset)
         && !$past(req_tvalid && req_tready)) |-> req_tready)
      else $error("Request side stalled while the unit is empty.");

endmodule

bind m68020_effective_address_unit eau_checker u_eau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/tb_m68020_effective_address_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the 68020 effective address unit
// Sends a short table of directed operands and then random operand streams,
// with memory indirect requests mostly followed by their long word, under
// several patterns of source idling and sink stalling. An internal predictor computes
// the results the table leaves open, and each result transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_m68020_effective_address_unit;
   import eau_pkg::*;

   localparam int NUM_DIRECTED = 26;
   localparam int HOLD_CYCLES = 300;
   localparam logic [3:0] EA_UNDEFINED = 4'd15;
   localparam logic [1:0] SIZE_RESERVED = 2'd3;
   localparam logic [1:0] NO_INDIRECT = 2'd0;
   localparam logic [15:0] EXT_LONG_INDEX = 16'h0800;
   localparam logic [15:0] EXT_SCALE_4 = 16'h0400;
   localparam logic [15:0] EXT_SCALE_8 = 16'h0600;
   localparam logic [15:0] EXT_FULL = 16'h0100;
   localparam logic [15:0] EXT_BASE_SUPPRESS = 16'h0080;
   localparam logic [15:0] EXT_INDEX_SUPPRESS = 16'h0040;
   localparam logic [15:0] EXT_BD_WORD = 16'(DISP_WORD) << 4;
   localparam logic [15:0] EXT_BD_LONG = 16'(DISP_LONG) << 4;
   localparam logic [15:0] EXT_POST_INDEX = 16'h0004;
   localparam logic [15:0] EXT_OD_NULL = 16'(DISP_NULL);
   localparam logic [15:0] EXT_OD_WORD = 16'(DISP_WORD);
   localparam logic [15:0] EXT_OD_LONG = 16'(DISP_LONG);

   typedef struct {
      eau_req_type op;
      bit          typed;
      eau_rsp_type rsp;
   } directed_row_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_WIDTH-1:0]  req_tdata = '0;
   logic                        req_tuser = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic [1:0]                  rsp_tuser;

   logic        read_pending = 1'b0;
   logic [31:0] read_addend = '0;
   eau_rsp_type expected_rsp [$];
   eau_rsp_type oldest_rsp;
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_active = 1'b0;
   directed_row_type directed_rows [NUM_DIRECTED];

   m68020_effective_address_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_m68020_effective_address_unit: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Predicts the result of one request and updates the pending indirect read exactly as the unit does.
   function automatic eau_rsp_type predict_ea(input eau_req_type op);
      eau_rsp_type res;
      logic [15:0] ew;
      logic [31:0] adr;
      logic [31:0] idx;
      logic [31:0] base;
      logic [31:0] outer;
      ew = op.ext_word;
      res.kind = KIND_ADDRESS;
      res.value = '0;
      if (op.mode == MODE_INDIRECT) begin
         if (read_pending) begin
            res.value = op.indirect_data + read_addend;
            read_pending = 1'b0;
            read_addend = '0;
         end else begin
            res.kind = KIND_UNEXPECTED;
         end
         return res;
      end
      read_pending = 1'b0;
      read_addend = '0;
      adr = (op.ea_mode == EA_PC_INDEX) ? op.pc_value + 32'd2 : op.base_value;
      case (op.ea_mode)
         EA_DATA_REG, EA_ADDR_REG: begin
            res.kind = KIND_OPERAND;
            case (op.size)
               SIZE_BYTE: res.value = {24'd0, op.base_value[7:0]};
               SIZE_WORD: res.value = {16'd0, op.base_value[15:0]};
               default:   res.value = op.base_value;
            endcase
         end
         EA_ADDR_IND, EA_POSTINC: res.value = op.base_value;
         EA_PREDEC: begin
            case (op.size)
               SIZE_BYTE: res.value = op.base_value
                                      - ((op.reg_num == STACK_REG) ? 32'd2 : 32'd1);
               SIZE_WORD: res.value = op.base_value - 32'd2;
               default:   res.value = op.base_value - 32'd4;
            endcase
         end
         EA_DISP16:    res.value = op.base_value + {{16{ew[15]}}, ew};
         EA_ABS_WORD:  res.value = {{16{ew[15]}}, ew};
         EA_ABS_LONG:  res.value = {ew, op.ext_word_next};
         EA_PC_DISP16: res.value = op.pc_value + 32'd2 + {{16{ew[15]}}, ew};
         EA_IMMEDIATE: begin
            res.kind = KIND_OPERAND;
            case (op.size)
               SIZE_BYTE: res.value = {24'd0, ew[7:0]};
               SIZE_WORD: res.value = {16'd0, ew};
               default:   res.value = {ew, op.ext_word_next};
            endcase
         end
         EA_INDEX, EA_PC_INDEX: begin
            idx = ew[11] ? op.index_value
                         : {{16{op.index_value[15]}}, op.index_value[15:0]};
            idx = idx << ew[10:9];
            if (!ew[8]) begin
               res.value = adr + idx + {{24{ew[7]}}, ew[7:0]};
            end else begin
               base = ew[7] ? '0 : adr;
               if (ew[6]) idx = '0;
               case (ew[5:4])
                  DISP_WORD: base += {{16{op.base_disp_words[15]}}, op.base_disp_words[15:0]};
                  DISP_LONG: base += op.base_disp_words;
                  default: ;
               endcase
               case (ew[1:0])
                  DISP_WORD: outer = {{16{op.outer_disp_words[15]}},
                                      op.outer_disp_words[15:0]};
                  DISP_LONG: outer = op.outer_disp_words;
                  default:   outer = '0;
               endcase
               if (!ew[2]) base += idx;
               if (ew[1:0] != NO_INDIRECT) begin
                  read_pending = 1'b1;
                  read_addend = outer + (ew[2] ? idx : 32'd0);
                  res.kind = KIND_READ_REQ;
                  res.value = base;
               end else begin
                  res.value = base + outer + (ew[2] ? idx : 32'd0);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic eau_req_type make_op(
      input logic m, input logic [3:0] ea, input logic [1:0] sz, input logic [2:0] rn,
      input logic [31:0] bv, input logic [31:0] pc, input logic [31:0] ix,
      input logic [15:0] ew, input logic [15:0] ewn,
      input logic [31:0] bd, input logic [31:0] od, input logic [31:0] rd);
      eau_req_type op;
      op.mode = m;
      op.ea_mode = ea;
      op.size = sz;
      op.reg_num = rn;
      op.base_value = bv;
      op.pc_value = pc;
      op.index_value = ix;
      op.ext_word = ew;
      op.ext_word_next = ewn;
      op.base_disp_words = bd;
      op.outer_disp_words = od;
      op.indirect_data = rd;
      return op;
   endfunction

   function automatic eau_req_type random_operand();
      eau_req_type op;
      int pick;
      op = make_op(MODE_COMPUTE, 4'($urandom_range(0, 11)), 2'($urandom_range(0, 3)),
                   3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                   16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         op.ea_mode = 4'($urandom_range(12, 15));
      end else if (pick < 50) begin
         op.ea_mode = ($urandom_range(0, 1) == 0) ? EA_INDEX : EA_PC_INDEX;
         op.ext_word[8] = ($urandom_range(0, 99) < 70);
      end
      if ($urandom_range(0, 99) < 5) op.mode = MODE_INDIRECT;
      return op;
   endfunction

   task automatic send_operand(input eau_req_type op, input bit typed,
                               input eau_rsp_type typed_rsp);
      eau_rsp_type due;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op.mode;
      req_tdata <= REQ_TDATA_WIDTH'({op.indirect_data, op.outer_disp_words,
                                     op.base_disp_words, op.ext_word_next, op.ext_word,
                                     op.index_value, op.pc_value, op.base_value,
                                     op.reg_num, op.size, op.ea_mode});
      do @(posedge clock); while (!req_tready);
      due = predict_ea(op);
      if (typed) due = typed_rsp;
      expected_rsp.push_back(due);
   endtask

   // A memory indirect request is usually followed by the long word it asks for.
   task automatic offer_random_operands(input int count);
      eau_req_type op;
      int sent;
      sent = 0;
      while (sent < count) begin
         op = random_operand();
         send_operand(op, 1'b0, '0);
         sent++;
         if (op.mode == MODE_COMPUTE && (op.ea_mode == EA_INDEX || op.ea_mode == EA_PC_INDEX)
             && op.ext_word[8] && op.ext_word[1:0] != NO_INDIRECT
             && $urandom_range(0, 99) < 85) begin
            op = random_operand();
            op.mode = MODE_INDIRECT;
            send_operand(op, 1'b0, '0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      wait (hold_req);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing expected: kind %0d value %h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            oldest_rsp = expected_rsp.pop_front();
            if (rsp_tuser !== oldest_rsp.kind)
               report_mismatch($sformatf("kind %0d, expected %0d (value %h)",
                                         rsp_tuser, oldest_rsp.kind, rsp_tdata));
            if (rsp_tdata !== oldest_rsp.value)
               report_mismatch($sformatf("value %h, expected %h (kind %0d)",
                                         rsp_tdata, oldest_rsp.value, oldest_rsp.kind));
         end
      end
   end

   initial begin
      directed_rows = '{
         '{make_op(MODE_INDIRECT, EA_DATA_REG, SIZE_LONG, 3'd0, '1, '1, '1, '1, '1, '1, '1, '1),
           1'b1, '{KIND_UNEXPECTED, 32'h0000_0000}},
         '{make_op(MODE_COMPUTE, EA_DATA_REG, SIZE_BYTE, 3'd0, '1, '0, '0, '0, '0, '0, '0, '0),
           1'b1, '{KIND_OPERAND, 32'h0000_00ff}},
         '{make_op(MODE_COMPUTE, EA_ADDR_REG, SIZE_WORD, 3'd7, '1, '0, '0, '0, '0, '0, '0, '0),
           1'b1, '{KIND_OPERAND, 32'h0000_ffff}},
         '{make_op(MODE_COMPUTE, EA_DATA_REG, SIZE_RESERVED, 3'd7, '1, '0, '0, '0, '0, '0, '0,
                   '0), 1'b1, '{KIND_OPERAND, 32'hffff_ffff}},
         '{make_op(MODE_COMPUTE, EA_ADDR_IND, SIZE_LONG, 3'd1, '1, '0, '0, '0, '0, '0, '0, '0),
           1'b1, '{KIND_ADDRESS, 32'hffff_ffff}},
         '{make_op(MODE_COMPUTE, EA_POSTINC, SIZE_BYTE, 3'd7, '0, '1, '1, '1, '1, '1, '1, '1),
           1'b1, '{KIND_ADDRESS, 32'h0000_0000}},
         '{make_op(MODE_COMPUTE, EA_PREDEC, SIZE_BYTE, STACK_REG, '0, '0, '0, '0, '0, '0, '0,
                   '0), 1'b1, '{KIND_ADDRESS, 32'hffff_fffe}},
         '{make_op(MODE_COMPUTE, EA_PREDEC, SIZE_BYTE, 3'd3, '0, '0, '0, '0, '0, '0, '0, '0),
           1'b1, '{KIND_ADDRESS, 32'hffff_ffff}},
         '{make_op(MODE_COMPUTE, EA_PREDEC, SIZE_WORD, STACK_REG, '0, '0, '0, '0, '0, '0, '0,
                   '0), 1'b1, '{KIND_ADDRESS, 32'hffff_fffe}},
         '{make_op(MODE_COMPUTE, EA_PREDEC, SIZE_LONG, 3'd0, '0, '0, '0, '0, '0, '0, '0, '0),
           1'b1, '{KIND_ADDRESS, 32'hffff_fffc}},
         '{make_op(MODE_COMPUTE, EA_DISP16, SIZE_WORD, 3'd2, '0, '0, '0, 16'h8000, '0, '0, '0,
                   '0), 1'b1, '{KIND_ADDRESS, 32'hffff_8000}},
         '{make_op(MODE_COMPUTE, EA_ABS_WORD, SIZE_WORD, 3'd0, '0, '0, '0, '1, '0, '0, '0, '0),
           1'b1, '{KIND_ADDRESS, 32'hffff_ffff}},
         '{make_op(MODE_COMPUTE, EA_ABS_LONG, SIZE_LONG, 3'd1, '0, '0, '0, 16'h1234, 16'habcd,
                   '0, '0, '0), 1'b1, '{KIND_ADDRESS, 32'h1234_abcd}},
         '{make_op(MODE_COMPUTE, EA_PC_DISP16, SIZE_LONG, 3'd2, '0, 32'hffff_fffe, '0, '0, '0,
                   '0, '0, '0), 1'b1, '{KIND_ADDRESS, 32'h0000_0000}},
         '{make_op(MODE_COMPUTE, EA_IMMEDIATE, SIZE_BYTE, 3'd4, '0, '0, '0, 16'habcd, 16'h1234,
                   '0, '0, '0), 1'b1, '{KIND_OPERAND, 32'h0000_00cd}},
         '{make_op(MODE_COMPUTE, EA_IMMEDIATE, SIZE_LONG, 3'd4, '0, '0, '0, 16'habcd, 16'h1234,
                   '0, '0, '0), 1'b1, '{KIND_OPERAND, 32'habcd_1234}},
         '{make_op(MODE_COMPUTE, EA_UNDEFINED, SIZE_LONG, 3'd5, '1, '1, '1, '1, '1, '1, '1, '1),
           1'b1, '{KIND_ADDRESS, 32'h0000_0000}},
         '{make_op(MODE_COMPUTE, EA_INDEX, SIZE_WORD, 3'd3, 32'h0000_1000, '0, 32'h0001_8000,
                   EXT_SCALE_8 | 16'ha080, '0, '0, '0, '0), 1'b0, '0},
         '{make_op(MODE_COMPUTE, EA_PC_INDEX, SIZE_LONG, 3'd2, '0, 32'h0040_0000, 32'h8000_0001,
                   EXT_LONG_INDEX | EXT_SCALE_4 | 16'h007f, '0, '0, '0, '0), 1'b0, '0},
         '{make_op(MODE_COMPUTE, EA_INDEX, SIZE_LONG, 3'd6, 32'h0001_0000, '0, 32'h0000_0010,
                   EXT_FULL | EXT_LONG_INDEX | EXT_BD_LONG | EXT_OD_WORD, '0, '1,
                   32'h0000_8000, '0), 1'b0, '0},
         '{make_op(MODE_INDIRECT, EA_DATA_REG, SIZE_LONG, 3'd0, '0, '0, '0, '0, '0, '0, '0,
                   32'h1234_5678), 1'b0, '0},
         '{make_op(MODE_COMPUTE, EA_PC_INDEX, SIZE_LONG, 3'd0, '0, 32'h0000_2000, 32'hffff_fff0,
                   EXT_FULL | EXT_SCALE_8 | EXT_BD_WORD | EXT_POST_INDEX | EXT_OD_LONG, '0,
                   32'h0000_ff00, 32'h7fff_ffff, '0), 1'b0, '0},
         '{make_op(MODE_COMPUTE, EA_INDEX, SIZE_WORD, 3'd1, 32'h0000_3000, '0, 32'h0000_0004,
                   EXT_FULL | EXT_BD_WORD | EXT_POST_INDEX, '0, 32'h0000_0100, '0, '0),
           1'b0, '0},
         '{make_op(MODE_INDIRECT, EA_DATA_REG, SIZE_LONG, 3'd0, '0, '0, '0, '0, '0, '0, '0, '1),
           1'b1, '{KIND_UNEXPECTED, 32'h0000_0000}},
         '{make_op(MODE_COMPUTE, EA_INDEX, SIZE_BYTE, 3'd7, '1, '0, '1,
                   EXT_FULL | EXT_BASE_SUPPRESS | EXT_INDEX_SUPPRESS | EXT_OD_NULL, '0, '1, '1,
                   '0), 1'b0, '0},
         '{make_op(MODE_INDIRECT, EA_DATA_REG, SIZE_LONG, 3'd0, '0, '0, '0, '0, '0, '0, '0, '1),
           1'b0, '0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_operand(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].rsp);
      end
      // The sink holds off while the source keeps offering, so the unit backs up.
      hold_req = 1'b1;
      offer_random_operands(60);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         offer_random_operands(310);
      end
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_m68020_effective_address_unit: PASS");
      end else begin
         $display("tb_m68020_effective_address_unit: FAIL");
      end
      $finish;
   end

endmodule
